// File: rtl/core/incremental_pid_with_stop_brake_assert.svh
// assertion macros for the incremental pid block
`ifndef INCREMENTAL_PID_WITH_STOP_BRAKE_ASSERT_SVH
`define INCREMENTAL_PID_WITH_STOP_BRAKE_ASSERT_SVH

// same-cycle implication
`define IPSB_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IPSB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ipsb_pkg.sv
// ----------------------------------------------------------------------------
// ipsb_pkg
// shared widths, register indexes, codes and command types
// ----------------------------------------------------------------------------
`default_nettype none

package ipsb_pkg;

   localparam int ACC_W = 64;
   localparam int MPL_W = 32;
   localparam int DVS_W = 16;
   localparam int DIV_CNT_W = $clog2(ACC_W);

   localparam logic [2:0] REG_GAIN_P = 3'd0;
   localparam logic [2:0] REG_GAIN_I = 3'd1;
   localparam logic [2:0] REG_GAIN_D = 3'd2;
   localparam logic [2:0] REG_OUTPUT_LIMIT = 3'd3;
   localparam logic [2:0] REG_SPEED_THRESHOLD = 3'd4;
   localparam logic [2:0] REG_BRAKE_NORMAL = 3'd5;
   localparam logic [2:0] REG_BRAKE_STRONG = 3'd6;
   localparam logic [2:0] REG_DEFAULT_PERIOD = 3'd7;

   localparam logic [1:0] MODE_REGULATE = 2'd0;
   localparam logic [1:0] MODE_IDLE = 2'd1;
   localparam logic [1:0] MODE_BRAKE = 2'd2;

   localparam logic [1:0] STOP_NONE = 2'd0;
   localparam logic [1:0] STOP_NORMAL = 2'd1;
   localparam logic [1:0] STOP_STRONG = 2'd2;
   // spare code, behaves as a normal stop
   localparam logic [1:0] STOP_SPARE = 2'd3;

   localparam logic [14:0] RST_OUTPUT_LIMIT = 15'd10000;
   localparam logic [14:0] RST_SPEED_THRESHOLD = 15'd2;
   localparam logic [14:0] RST_BRAKE_NORMAL = 15'd3000;
   localparam logic [14:0] RST_BRAKE_STRONG = 15'd6000;
   localparam logic [15:0] RST_DEFAULT_PERIOD = 16'd5000;

   // integral term: ki*e*p*4 / 15625, derivative term: kd*dd*256000000 / p
   localparam logic [DVS_W-1:0] I_DIVISOR = 16'd15625;
   localparam logic [ACC_W-1:0] I_ROUND = 64'd7812;
   localparam logic [MPL_W-1:0] D_SCALE = 32'd256000000;

   typedef struct packed {
      logic go;
      logic [ACC_W-1:0] mcand;
      logic [MPL_W-1:0] mplier;
   } mul_cmd_type;

   typedef struct packed {
      logic go;
      logic [ACC_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_cmd_type;

endpackage

`default_nettype wire

// File: rtl/core/ipsb_mul.sv
// ----------------------------------------------------------------------------
// ipsb_mul
// bit-serial shift-add multiplier on magnitudes, one multiplier bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ipsb_mul (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ipsb_pkg::mul_cmd_type cmd,
   output logic done,
   output logic [ipsb_pkg::ACC_W-1:0] product
);

   logic [ipsb_pkg::ACC_W-1:0] a_ff, a_in, p_ff, p_in;
   logic [ipsb_pkg::MPL_W-1:0] b_ff, b_in;
   logic run_ff, run_in, done_ff, done_in;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (cmd.go) begin
         a_in = cmd.mcand;
         b_in = cmd.mplier;
         p_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            p_in = p_ff + a_ff;
         end
         a_in = {a_ff[ipsb_pkg::ACC_W-2:0], 1'b0};
         b_in = {1'b0, b_ff[ipsb_pkg::MPL_W-1:1]};
         // stop early once no set multiplier bits remain
         if (b_ff[ipsb_pkg::MPL_W-1:1] == '0) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// File: rtl/core/ipsb_div.sv
// ----------------------------------------------------------------------------
// ipsb_div
// restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ipsb_div (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ipsb_pkg::div_cmd_type cmd,
   output logic done,
   output logic [ipsb_pkg::ACC_W-1:0] quotient
);

   localparam logic [ipsb_pkg::DIV_CNT_W-1:0] LAST_CNT =
      ipsb_pkg::DIV_CNT_W'(ipsb_pkg::ACC_W - 1);

   logic [ipsb_pkg::ACC_W-1:0] q_ff, q_in;
   logic [ipsb_pkg::DVS_W-1:0] r_ff, r_in, d_ff, d_in;
   logic [ipsb_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in;
   logic [ipsb_pkg::DVS_W:0] trial, diff;
   logic fits;

   assign trial = {r_ff, q_ff[ipsb_pkg::ACC_W-1]};
   assign diff = trial - {1'b0, d_ff};
   assign fits = trial >= {1'b0, d_ff};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (cmd.go) begin
         q_in = cmd.dividend;
         r_in = '0;
         d_in = cmd.divisor;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         r_in = fits ? diff[ipsb_pkg::DVS_W-1:0] : trial[ipsb_pkg::DVS_W-1:0];
         q_in = {q_ff[ipsb_pkg::ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = q_ff;

endmodule

`default_nettype wire

// File: rtl/core/incremental_pid_with_stop_brake.sv
// sequence: a zero target passes from the prep state straight to the output state;
//   otherwise two divisions and five serial products, each product stopping early once
//   no set multiplier bits remain, with the prep, start, clamp and output states around them
// one tick at a time, the next transfer taken once the result is raised
// a new tick is taken while the previous result still waits in the output register
// reset (synchronous): history and accumulator cleared, registers to defaults
// ----------------------------------------------------------------------------
// incremental_pid_with_stop_brake
// velocity-form pid speed controller with stop braking, serial arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module incremental_pid_with_stop_brake (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic signed [15:0] req_speed_target,
   input  wire logic signed [15:0] req_speed_measured,
   input  wire logic [15:0] req_period_us,
   input  wire logic [1:0] req_stop_request,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [15:0] rsp_drive_duty,
   output logic [1:0] rsp_tick_mode,
   input  wire logic csr_wen,
   input  wire logic [2:0] csr_index,
   input  wire logic [15:0] csr_wdata
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_PREP = 4'd1;
   localparam logic [3:0] ST_START = 4'd2;
   localparam logic [3:0] ST_MUL_P = 4'd3;
   localparam logic [3:0] ST_MUL_IE = 4'd4;
   localparam logic [3:0] ST_MUL_IP = 4'd5;
   localparam logic [3:0] ST_DIV_I = 4'd6;
   localparam logic [3:0] ST_MUL_DK = 4'd7;
   localparam logic [3:0] ST_MUL_DC = 4'd8;
   localparam logic [3:0] ST_DIV_D = 4'd9;
   localparam logic [3:0] ST_CLAMP = 4'd10;
   localparam logic [3:0] ST_OUT = 4'd11;

   localparam int AW = ipsb_pkg::ACC_W;

   // configuration
   logic signed [15:0] kp_ff, ki_ff, kd_ff;
   logic [14:0] lim_ff, thr_ff, brk_n_ff, brk_s_ff;
   logic [15:0] dper_ff;

   // item and state
   logic [3:0] state_ff, state_in;
   logic signed [15:0] tgt_ff, fb_ff;
   logic [15:0] per_ff, per_in;
   logic [1:0] stop_ff;
   logic signed [16:0] e_ff, e_in, e1_ff, e1_in, e2_ff, e2_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [AW-1:0] sum_ff, sum_in;
   logic [1:0] mode_ff, mode_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] duty_ff, duty_in;
   logic [1:0] tmode_ff, tmode_in;

   ipsb_pkg::mul_cmd_type mul_cmd;
   ipsb_pkg::div_cmd_type div_cmd;
   logic mul_done, div_done;
   logic [AW-1:0] mul_prod, div_quo;

   // derived values
   logic signed [17:0] de;
   logic signed [18:0] dd2;
   logic [17:0] de_mag;
   logic [18:0] dd2_mag;
   logic [16:0] e_mag;
   logic [15:0] kp_mag, ki_mag, kd_mag;
   logic kp_neg, ki_neg, kd_neg;
   logic signed [16:0] fb_ext;
   logic [16:0] fb_mag;
   logic [14:0] brk_sel, brk_duty;
   logic signed [15:0] brk_out;
   logic signed [AW-1:0] term_p, term_q, lim_q;
   logic [31:0] acc_mag;
   logic [15:0] acc_int;
   logic out_free;

   assign de = 18'(e_ff) - 18'(e1_ff);
   assign dd2 = 19'(e_ff) - (19'(e1_ff) <<< 1) + 19'(e2_ff);
   assign de_mag = de[17] ? 18'(-de) : 18'(de);
   assign dd2_mag = dd2[18] ? 19'(-dd2) : 19'(dd2);
   assign e_mag = e_ff[16] ? 17'(-e_ff) : 17'(e_ff);
   assign kp_neg = kp_ff[15];
   assign ki_neg = ki_ff[15];
   assign kd_neg = kd_ff[15];
   assign kp_mag = kp_neg ? 16'(-kp_ff) : 16'(kp_ff);
   assign ki_mag = ki_neg ? 16'(-ki_ff) : 16'(ki_ff);
   assign kd_mag = kd_neg ? 16'(-kd_ff) : 16'(kd_ff);

   assign fb_ext = 17'(fb_ff);
   assign fb_mag = fb_ext[16] ? 17'(-fb_ext) : 17'(fb_ext);
   assign brk_sel = (stop_ff == ipsb_pkg::STOP_STRONG) ? brk_s_ff : brk_n_ff;
   assign brk_duty = (brk_sel > lim_ff) ? lim_ff : brk_sel;
   assign brk_out = (fb_ff > 16'sd0) ? -$signed({1'b0, brk_duty}) : $signed({1'b0, brk_duty});

   // p term is exact, shifted into the q16 accumulator
   assign term_p = (kp_neg ^ de[17]) ? -$signed({mul_prod[AW-9:0], 8'd0})
                                     : $signed({mul_prod[AW-9:0], 8'd0});
   assign term_q = ((state_ff == ST_DIV_I) ? (ki_neg ^ e_ff[16]) : (kd_neg ^ dd2[18]))
                   ? -$signed(div_quo) : $signed(div_quo);
   assign lim_q = $signed({33'd0, lim_ff, 16'd0});

   // drive duty truncated toward zero
   assign acc_mag = acc_ff[31] ? 32'(-acc_ff) : 32'(acc_ff);
   assign acc_int = acc_mag[31:16];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      per_in = per_ff;
      e_in = e_ff;
      e1_in = e1_ff;
      e2_in = e2_ff;
      acc_in = acc_ff;
      sum_in = sum_ff;
      mode_in = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      duty_in = duty_ff;
      tmode_in = tmode_ff;
      mul_cmd = '0;
      div_cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PREP;
               if (req_period_us != 16'd0) begin
                  per_in = req_period_us;
               end else if (dper_ff != 16'd0) begin
                  per_in = dper_ff;
               end else begin
                  per_in = 16'd1;
               end
            end
         end
         ST_PREP: begin
            if (tgt_ff == 16'sd0) begin
               state_in = ST_OUT;
               if (stop_ff != ipsb_pkg::STOP_NONE && fb_mag > {2'b00, thr_ff}) begin
                  e1_in = -fb_ext;
                  e2_in = -fb_ext;
                  acc_in = {brk_out, 16'd0};
                  mode_in = ipsb_pkg::MODE_BRAKE;
               end else begin
                  e1_in = '0;
                  e2_in = '0;
                  acc_in = '0;
                  mode_in = ipsb_pkg::MODE_IDLE;
               end
            end else begin
               state_in = ST_START;
               e_in = 17'(tgt_ff) - 17'(fb_ff);
               sum_in = AW'(acc_ff);
               mode_in = ipsb_pkg::MODE_REGULATE;
            end
         end
         ST_START: begin
            mul_cmd.go = 1'b1;
            mul_cmd.mcand = AW'(kp_mag);
            mul_cmd.mplier = 32'(de_mag);
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            if (mul_done) begin
               sum_in = sum_ff + term_p;
               mul_cmd.go = 1'b1;
               mul_cmd.mcand = AW'(ki_mag);
               mul_cmd.mplier = 32'(e_mag);
               state_in = ST_MUL_IE;
            end
         end
         ST_MUL_IE: begin
            if (mul_done) begin
               mul_cmd.go = 1'b1;
               mul_cmd.mcand = mul_prod;
               mul_cmd.mplier = 32'(per_ff);
               state_in = ST_MUL_IP;
            end
         end
         ST_MUL_IP: begin
            if (mul_done) begin
               div_cmd.go = 1'b1;
               div_cmd.dividend = {mul_prod[AW-3:0], 2'b00} + ipsb_pkg::I_ROUND;
               div_cmd.divisor = ipsb_pkg::I_DIVISOR;
               state_in = ST_DIV_I;
            end
         end
         ST_DIV_I: begin
            if (div_done) begin
               sum_in = sum_ff + term_q;
               mul_cmd.go = 1'b1;
               mul_cmd.mcand = AW'(kd_mag);
               mul_cmd.mplier = 32'(dd2_mag);
               state_in = ST_MUL_DK;
            end
         end
         ST_MUL_DK: begin
            if (mul_done) begin
               mul_cmd.go = 1'b1;
               mul_cmd.mcand = mul_prod;
               mul_cmd.mplier = ipsb_pkg::D_SCALE;
               state_in = ST_MUL_DC;
            end
         end
         ST_MUL_DC: begin
            if (mul_done) begin
               div_cmd.go = 1'b1;
               div_cmd.dividend = mul_prod + AW'(per_ff[15:1]);
               div_cmd.divisor = per_ff;
               state_in = ST_DIV_D;
            end
         end
         ST_DIV_D: begin
            if (div_done) begin
               sum_in = sum_ff + term_q;
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (sum_ff > lim_q) begin
               acc_in = lim_q[31:0];
            end else if (sum_ff < -lim_q) begin
               acc_in = 32'(-lim_q);
            end else begin
               acc_in = sum_ff[31:0];
            end
            e2_in = e1_ff;
            e1_in = e_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               duty_in = acc_ff[31] ? 16'(-acc_int) : acc_int;
               tmode_in = mode_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      per_ff <= per_in;
      e_ff <= e_in;
      sum_ff <= sum_in;
      mode_ff <= mode_in;
      duty_ff <= duty_in;
      tmode_ff <= tmode_in;
      if (req_valid && req_ready) begin
         tgt_ff <= req_speed_target;
         fb_ff <= req_speed_measured;
         stop_ff <= req_stop_request;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         e1_ff <= '0;
         e2_ff <= '0;
         acc_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         acc_ff <= acc_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0;
         ki_ff <= '0;
         kd_ff <= '0;
         lim_ff <= ipsb_pkg::RST_OUTPUT_LIMIT;
         thr_ff <= ipsb_pkg::RST_SPEED_THRESHOLD;
         brk_n_ff <= ipsb_pkg::RST_BRAKE_NORMAL;
         brk_s_ff <= ipsb_pkg::RST_BRAKE_STRONG;
         dper_ff <= ipsb_pkg::RST_DEFAULT_PERIOD;
      end else if (csr_wen) begin
         case (csr_index)
            ipsb_pkg::REG_GAIN_P: kp_ff <= csr_wdata;
            ipsb_pkg::REG_GAIN_I: ki_ff <= csr_wdata;
            ipsb_pkg::REG_GAIN_D: kd_ff <= csr_wdata;
            ipsb_pkg::REG_OUTPUT_LIMIT: lim_ff <= csr_wdata[14:0];
            ipsb_pkg::REG_SPEED_THRESHOLD: thr_ff <= csr_wdata[14:0];
            ipsb_pkg::REG_BRAKE_NORMAL: brk_n_ff <= csr_wdata[14:0];
            ipsb_pkg::REG_BRAKE_STRONG: brk_s_ff <= csr_wdata[14:0];
            ipsb_pkg::REG_DEFAULT_PERIOD: dper_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   ipsb_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .done    (mul_done),
      .product (mul_prod)
   );

   ipsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_duty = duty_ff;
   assign rsp_tick_mode = tmode_ff;

endmodule

`default_nettype wire

// File: rtl/core/ipsb_checker.sv
// ----------------------------------------------------------------------------
// ipsb_checker
// port-level checks on the incremental pid block
// ----------------------------------------------------------------------------
`default_nettype none

`include "incremental_pid_with_stop_brake_assert.svh"

module ipsb_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic signed [15:0] rsp_drive_duty,
   input wire logic [1:0] rsp_tick_mode
);

   // a held result keeps its payload
   `IPSB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive_duty) && $stable(rsp_tick_mode), "result changed while stalled")

   // only one tick in flight
   `IPSB_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "accepted while busy")

   // idle tick gives zero drive
   `IPSB_ASSERT_NOW(a_idle_zero, clock, reset, rsp_valid && rsp_tick_mode == ipsb_pkg::MODE_IDLE, rsp_drive_duty == 16'sd0, "idle tick with non-zero duty")

   // saturation never reaches the most negative code
   `IPSB_ASSERT_NOW(a_duty_range, clock, reset, rsp_valid, rsp_drive_duty != 16'sh8000, "duty out of range")

endmodule

bind incremental_pid_with_stop_brake ipsb_checker u_ipsb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_drive_duty (rsp_drive_duty),
   .rsp_tick_mode  (rsp_tick_mode)
);

`default_nettype wire
